// ===== rtl/core/imcsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imcsc_pkg
// types, codes and constants shared by the intake mode and colour sort control
// ----------------------------------------------------------------------------
package imcsc_pkg;

	// intake mode codes
	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_FORWARD = 3'd1;
	localparam logic [2:0] MODE_REVERSE = 3'd2;
	localparam logic [2:0] MODE_LOW     = 3'd3;
	localparam logic [2:0] MODE_MIDDLE  = 3'd4;
	localparam logic [2:0] MODE_TOP     = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_ALLIANCE_IS_BLUE    = 3'd0;
	localparam logic [2:0] REG_SORT_ENABLE         = 3'd1;
	localparam logic [2:0] REG_PROXIMITY_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_SCORE_LIMIT         = 3'd3;
	localparam logic [2:0] REG_SCORE_TRIGGER       = 3'd4;
	localparam logic [2:0] REG_SCORE_RISE          = 3'd5;
	localparam logic [2:0] REG_SCORE_FALL          = 3'd6;
	localparam logic [2:0] REG_SAMPLE_PERIOD       = 3'd7;

	// roller speeds in rpm
	localparam logic signed [8:0] SPEED_ZERO = 9'sd0;
	localparam logic signed [8:0] SPEED_POS  = 9'sd200;
	localparam logic signed [8:0] SPEED_NEG  = -9'sd200;

	// hue windows in degrees
	localparam logic [8:0] HUE_RED_LO  = 9'd300;
	localparam logic [8:0] HUE_RED_HI  = 9'd360;
	localparam logic [8:0] HUE_BLUE_LO = 9'd215;
	localparam logic [8:0] HUE_BLUE_HI = 9'd250;

	// sample period clamp
	localparam logic [3:0] PERIOD_MIN = 4'd1;
	localparam logic [3:0] PERIOD_MAX = 4'd8;

	// register reset values
	localparam logic       RST_ALLIANCE_IS_BLUE    = 1'b0;
	localparam logic       RST_SORT_ENABLE         = 1'b1;
	localparam logic [7:0] RST_PROXIMITY_THRESHOLD = 8'd40;
	localparam logic [5:0] RST_SCORE_LIMIT         = 6'd10;
	localparam logic [5:0] RST_SCORE_TRIGGER       = 6'd3;
	localparam logic [5:0] RST_SCORE_RISE          = 6'd5;
	localparam logic [5:0] RST_SCORE_FALL          = 6'd3;
	localparam logic [3:0] RST_SAMPLE_PERIOD       = 4'd3;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		logic       alliance_is_blue;
		logic       sort_enable;
		logic [7:0] proximity_threshold;
		logic [5:0] score_limit;
		logic [5:0] score_trigger;
		logic [5:0] score_rise;
		logic [5:0] score_fall;
		logic [3:0] sample_period;
	} cfg_t;

	typedef struct packed {
		logic [5:0] btn;
		logic [7:0] proximity;
		logic [8:0] hue_deg;
	} item_t;

	typedef struct packed {
		logic signed [8:0] back_speed;
		logic signed [8:0] front_speed;
		logic signed [8:0] top_speed;
		logic signed [8:0] index_speed;
		logic              hood_raised;
		logic              tube_out;
		logic [2:0]        mode;
	} result_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [5:0]        prev_btn;
		logic [5:0]        score;
		logic [2:0]        phase;
		logic signed [8:0] top_cmd;
		logic              hood;
		logic              tube;
	} state_t;

	function automatic logic [2:0] toggle_mode(input logic [2:0] cur, input logic [2:0] target);
		return (cur == target) ? MODE_OFF : target;
	endfunction

endpackage

// ===== rtl/core/imcsc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imcsc_step
// next state and roller commands for one control tick
// ----------------------------------------------------------------------------
module imcsc_step (
	input  imcsc_pkg::state_t  st,
	input  imcsc_pkg::cfg_t    cfg,
	input  imcsc_pkg::item_t   item,
	output imcsc_pkg::state_t  st_nxt,
	output imcsc_pkg::result_t res
);
	import imcsc_pkg::*;

	logic [5:0]        rise;
	logic [2:0]        mode;
	logic              hood;
	logic              tube;
	logic              colour_hit;
	logic [6:0]        score_sum;
	logic [5:0]        score;
	logic [3:0]        period;
	logic [3:0]        phase_inc;
	logic signed [8:0] back_v;
	logic signed [8:0] front_v;
	logic signed [8:0] top_v;
	logic signed [8:0] index_v;

	// opposing colour detection
	always_comb begin
		colour_hit = 1'b0;
		if (cfg.sort_enable && (item.proximity > cfg.proximity_threshold)) begin
			if (item.hue_deg inside {[HUE_RED_LO:HUE_RED_HI]}) begin
				colour_hit = cfg.alliance_is_blue;
			end else if (item.hue_deg inside {[HUE_BLUE_LO:HUE_BLUE_HI]}) begin
				colour_hit = !cfg.alliance_is_blue;
			end
		end
	end

	// button edges, later buttons win
	always_comb begin
		rise = item.btn & ~st.prev_btn;
		mode = st.mode;
		hood = st.hood;
		tube = st.tube;
		if (rise[0]) begin
			mode = toggle_mode(mode, MODE_FORWARD);
			if (mode == MODE_FORWARD) begin
				hood = 1'b0;
			end
		end
		if (rise[1]) begin
			mode = toggle_mode(mode, MODE_REVERSE);
		end
		if (rise[2]) begin
			mode = toggle_mode(mode, MODE_MIDDLE);
		end
		if (rise[3]) begin
			mode = toggle_mode(mode, MODE_LOW);
		end
		if (rise[4]) begin
			mode = toggle_mode(mode, MODE_TOP);
			if (mode == MODE_TOP) begin
				hood = 1'b1;
				tube = 1'b0;
			end
		end
		if (rise[5]) begin
			tube = !tube;
		end
	end

	// score and roller speeds
	always_comb begin
		score_sum = {1'b0, st.score} + {1'b0, cfg.score_rise};
		score     = st.score;
		back_v    = SPEED_ZERO;
		front_v   = SPEED_ZERO;
		top_v     = SPEED_ZERO;
		index_v   = SPEED_ZERO;
		case (mode)
			MODE_FORWARD: begin
				if (st.phase == 3'd0) begin
					if (colour_hit) begin
						score = (score_sum < {1'b0, cfg.score_limit}) ? score_sum[5:0]
							: cfg.score_limit;
					end else begin
						score = (st.score > cfg.score_fall) ? st.score - cfg.score_fall
							: 6'd0;
					end
				end
				back_v  = SPEED_POS;
				front_v = SPEED_POS;
				top_v   = (score >= cfg.score_trigger) ? SPEED_NEG : SPEED_POS;
			end
			MODE_REVERSE: begin
				back_v  = SPEED_NEG;
				front_v = SPEED_NEG;
				top_v   = SPEED_NEG;
			end
			MODE_MIDDLE: begin
				back_v  = SPEED_POS;
				front_v = SPEED_POS;
				top_v   = SPEED_NEG;
				index_v = SPEED_POS;
			end
			MODE_LOW: begin
				back_v  = SPEED_POS;
				front_v = SPEED_NEG;
				top_v   = st.top_cmd;
				index_v = SPEED_POS;
			end
			MODE_TOP: begin
				back_v  = SPEED_POS;
				front_v = SPEED_POS;
				top_v   = SPEED_POS;
				index_v = SPEED_POS;
			end
			default: begin
			end
		endcase
	end

	// sample phase, period clamped to 1..8
	always_comb begin
		if (cfg.sample_period < PERIOD_MIN) begin
			period = PERIOD_MIN;
		end else if (cfg.sample_period > PERIOD_MAX) begin
			period = PERIOD_MAX;
		end else begin
			period = cfg.sample_period;
		end
		phase_inc = {1'b0, st.phase} + 4'd1;
	end

	always_comb begin
		st_nxt.mode     = mode;
		st_nxt.prev_btn = item.btn;
		st_nxt.score    = score;
		st_nxt.phase    = (phase_inc >= period) ? 3'd0 : phase_inc[2:0];
		st_nxt.top_cmd  = top_v;
		st_nxt.hood     = hood;
		st_nxt.tube     = tube;

		res.back_speed  = back_v;
		res.front_speed = front_v;
		res.top_speed   = top_v;
		res.index_speed = index_v;
		res.hood_raised = hood;
		res.tube_out    = tube;
		res.mode        = mode;
	end

endmodule

// ===== rtl/core/intake_mode_color_sort_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intake_mode_color_sort_control
// intake mode sequencing and colour sort for one control tick per beat
// ----------------------------------------------------------------------------
// the input beat is captured in the input register, and its result beat moves into
// the output register when that is empty or its current beat is being taken
// throughput: one tick per cycle unless output stalls, set by the state update loop
// an input register and an output register sit between the two streams, ready
// passes back through them so a stalled output holds off the input once both are full
// reset: mode off, score, phase, edges and solenoids cleared, registers to defaults
// ----------------------------------------------------------------------------
module intake_mode_color_sort_control (
	input  logic        clk,
	input  logic        arst_n,
	// ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	// btn_forward, btn_reverse, btn_middle, btn_low, btn_top, btn_tube,
	// proximity[7:0], hue_deg[8:0], zero pad
	input  logic [23:0] s_tdata,
	// roller commands
	output logic        m_tvalid,
	input  logic        m_tready,
	// back_speed[8:0], front_speed[8:0], top_speed[8:0], index_speed[8:0],
	// hood_raised, tube_out, mode[2:0], zero pad
	output logic [47:0] m_tdata,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import imcsc_pkg::*;

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_nxt;
	item_t   item_s1;
	item_t   item_in;
	logic    valid_s1;
	result_t res_s2;
	result_t res_nxt;
	logic    valid_s2;
	logic    adv_s2;
	logic    take_s1;

	assign item_in.btn       = s_tdata[5:0];
	assign item_in.proximity = s_tdata[13:6];
	assign item_in.hue_deg   = s_tdata[22:14];

	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign take_s1  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alliance_is_blue    <= RST_ALLIANCE_IS_BLUE;
			cfg_q.sort_enable         <= RST_SORT_ENABLE;
			cfg_q.proximity_threshold <= RST_PROXIMITY_THRESHOLD;
			cfg_q.score_limit         <= RST_SCORE_LIMIT;
			cfg_q.score_trigger       <= RST_SCORE_TRIGGER;
			cfg_q.score_rise          <= RST_SCORE_RISE;
			cfg_q.score_fall          <= RST_SCORE_FALL;
			cfg_q.sample_period       <= RST_SAMPLE_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALLIANCE_IS_BLUE:    cfg_q.alliance_is_blue    <= cfg_data[0];
				REG_SORT_ENABLE:         cfg_q.sort_enable         <= cfg_data[0];
				REG_PROXIMITY_THRESHOLD: cfg_q.proximity_threshold <= cfg_data;
				REG_SCORE_LIMIT:         cfg_q.score_limit         <= cfg_data[5:0];
				REG_SCORE_TRIGGER:       cfg_q.score_trigger       <= cfg_data[5:0];
				REG_SCORE_RISE:          cfg_q.score_rise          <= cfg_data[5:0];
				REG_SCORE_FALL:          cfg_q.score_fall          <= cfg_data[5:0];
				REG_SAMPLE_PERIOD:       cfg_q.sample_period       <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			item_s1 <= item_in;
		end
	end

	imcsc_step u_step (
		.st     (st_q),
		.cfg    (cfg_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode     <= MODE_OFF;
			st_q.prev_btn <= 6'd0;
			st_q.score    <= 6'd0;
			st_q.phase    <= 3'd0;
			st_q.top_cmd  <= SPEED_ZERO;
			st_q.hood     <= 1'b0;
			st_q.tube     <= 1'b0;
		end else if (adv_s2) begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.mode, res_s2.tube_out, res_s2.hood_raised,
		res_s2.index_speed, res_s2.top_speed, res_s2.front_speed, res_s2.back_speed};

endmodule

// ===== rtl/core/imcsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imcsc_checker
// port-level checks on the intake mode and colour sort control
// ----------------------------------------------------------------------------
module imcsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);
	import imcsc_pkg::*;

	logic [2:0] out_mode;
	logic       out_hood;

	assign out_mode = m_tdata[40:38];
	assign out_hood = m_tdata[36];

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// off mode drives all rollers to zero
	a_off_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_mode == MODE_OFF) |-> (m_tdata[35:0] == 36'd0))
		else $error("roller running in off mode");

	// reverse runs back, front and top rollers backwards with index stopped
	a_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_mode == MODE_REVERSE) |->
		(m_tdata[8:0] == SPEED_NEG) && (m_tdata[17:9] == SPEED_NEG) &&
		(m_tdata[26:18] == SPEED_NEG) && (m_tdata[35:27] == SPEED_ZERO))
		else $error("wrong roller speeds in reverse mode");

	// hood stays raised in top mode
	a_top_hood: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_mode == MODE_TOP) |-> out_hood)
		else $error("hood lowered in top mode");

endmodule

bind intake_mode_color_sort_control imcsc_checker u_imcsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the intake mode and colour sort control
// ----------------------------------------------------------------------------
// Control ticks go in as stream beats, and each command beat that comes out is
// compared field by field with the oldest entry of a queue of predicted
// commands. The predictor keeps its own copy of the mode, button, score, phase
// and solenoid state. Named tests cover button edges and mode priority, the
// colour windows and thresholds, the sample phase wrap, a long output stall
// that backs up the input, and random ticks under a sweep of register
// settings. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import imcsc_pkg::*;

	localparam int TIMEOUT_CYCLES = 200000;
	localparam logic [4:0][2:0] PRESS_MODES =
		{MODE_TOP, MODE_LOW, MODE_MIDDLE, MODE_REVERSE, MODE_FORWARD};
	localparam logic [7:0][8:0] HUE_EDGES =
		{9'd214, 9'd215, 9'd250, 9'd251, 9'd299, 9'd300, 9'd360, 9'd361};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// btn_forward, btn_reverse, btn_middle, btn_low, btn_top, btn_tube,
	// proximity[7:0], hue_deg[8:0], zero pad
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// back_speed[8:0], front_speed[8:0], top_speed[8:0], index_speed[8:0],
	// hood_raised, tube_out, mode[2:0], zero pad
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	cfg_t    sort_cfg;
	state_t  intake_st;
	result_t pending_cmds [$];

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int hold_cycles = 0;
	int errors = 0;
	int ticks_sent = 0;
	int cmds_checked = 0;
	int reg_writes = 0;
	int cycle_count = 0;
	int input_stalls = 0;

	intake_mode_color_sort_control i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (s_tvalid && !s_tready)
			input_stalls <= input_stalls + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// predicted roller commands for one tick, advancing the intake state
	function automatic result_t advance_intake(input logic [5:0] btn, input logic [7:0] prox,
			input logic [8:0] hue);
		logic [5:0] rise;
		int         s;
		int         period;
		result_t    r;
		rise = btn & ~intake_st.prev_btn;
		intake_st.prev_btn = btn;
		for (int i = 0; i < 5; i++) begin
			if (rise[i]) begin
				intake_st.mode = (intake_st.mode == PRESS_MODES[i]) ? MODE_OFF : PRESS_MODES[i];
				if (i == 0 && intake_st.mode == MODE_FORWARD)
					intake_st.hood = 1'b0;
				if (i == 4 && intake_st.mode == MODE_TOP) begin
					intake_st.hood = 1'b1;
					intake_st.tube = 1'b0;
				end
			end
		end
		r = '0;
		r.back_speed  = SPEED_ZERO;
		r.front_speed = SPEED_ZERO;
		r.top_speed   = SPEED_ZERO;
		r.index_speed = SPEED_ZERO;
		case (intake_st.mode)
			MODE_FORWARD: begin
				if (intake_st.phase == 3'd0) begin
					if (sort_cfg.sort_enable && prox > sort_cfg.proximity_threshold &&
							((hue >= HUE_RED_LO && hue <= HUE_RED_HI && sort_cfg.alliance_is_blue) ||
							(hue >= HUE_BLUE_LO && hue <= HUE_BLUE_HI && !sort_cfg.alliance_is_blue)))
							begin
						s = intake_st.score + sort_cfg.score_rise;
						intake_st.score = (s < sort_cfg.score_limit) ? s[5:0] : sort_cfg.score_limit;
					end else begin
						intake_st.score = (intake_st.score > sort_cfg.score_fall) ?
							intake_st.score - sort_cfg.score_fall : 6'd0;
					end
				end
				r.back_speed  = SPEED_POS;
				r.front_speed = SPEED_POS;
				r.top_speed   = (intake_st.score >= sort_cfg.score_trigger) ? SPEED_NEG : SPEED_POS;
			end
			MODE_REVERSE: begin
				r.back_speed  = SPEED_NEG;
				r.front_speed = SPEED_NEG;
				r.top_speed   = SPEED_NEG;
			end
			MODE_MIDDLE: begin
				r.back_speed  = SPEED_POS;
				r.front_speed = SPEED_POS;
				r.top_speed   = SPEED_NEG;
				r.index_speed = SPEED_POS;
			end
			MODE_LOW: begin
				r.back_speed  = SPEED_POS;
				r.front_speed = SPEED_NEG;
				r.top_speed   = intake_st.top_cmd;
				r.index_speed = SPEED_POS;
			end
			MODE_TOP: begin
				r.back_speed  = SPEED_POS;
				r.front_speed = SPEED_POS;
				r.top_speed   = SPEED_POS;
				r.index_speed = SPEED_POS;
			end
			default: begin
			end
		endcase
		intake_st.top_cmd = r.top_speed;
		if (rise[5])
			intake_st.tube = ~intake_st.tube;
		period = sort_cfg.sample_period;
		if (period == 0)
			period = 1;
		if (period > 8)
			period = 8;
		intake_st.phase = (int'(intake_st.phase) + 1 >= period) ? 3'd0 : intake_st.phase + 3'd1;
		r.hood_raised = intake_st.hood;
		r.tube_out    = intake_st.tube;
		r.mode        = intake_st.mode;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endtask

	// command beat checker
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.back_speed  = m_tdata[8:0];
			got.front_speed = m_tdata[17:9];
			got.top_speed   = m_tdata[26:18];
			got.index_speed = m_tdata[35:27];
			got.hood_raised = m_tdata[36];
			got.tube_out    = m_tdata[37];
			got.mode        = m_tdata[40:38];
			if (pending_cmds.size() == 0) begin
				$error("command beat with none pending, mode %0d", got.mode);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				check_field("back_speed", want.back_speed, got.back_speed);
				check_field("front_speed", want.front_speed, got.front_speed);
				check_field("top_speed", want.top_speed, got.top_speed);
				check_field("index_speed", want.index_speed, got.index_speed);
				check_field("hood_raised", want.hood_raised, got.hood_raised);
				check_field("tube_out", want.tube_out, got.tube_out);
				check_field("mode", want.mode, got.mode);
				cmds_checked++;
			end
		end
	end

	// command sink with random stalls and an occasional long hold-off
	initial begin
		int w;
		wait (arst_n);
		@(negedge clk);
		forever begin
			w = rx_gaps ? $urandom_range(0, 4) : 0;
			if (hold_cycles > 0) begin
				w = hold_cycles;
				hold_cycles = 0;
			end
			if (w > 0) begin
				m_tready = 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_tick(input logic [5:0] btn, input logic [7:0] prox, input logic [8:0] hue);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {1'b0, hue, prox, btn};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_cmds.push_back(advance_intake(btn, prox, hue));
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		wait (pending_cmds.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ALLIANCE_IS_BLUE:    sort_cfg.alliance_is_blue    = val[0];
			REG_SORT_ENABLE:         sort_cfg.sort_enable         = val[0];
			REG_PROXIMITY_THRESHOLD: sort_cfg.proximity_threshold = val;
			REG_SCORE_LIMIT:         sort_cfg.score_limit         = val[5:0];
			REG_SCORE_TRIGGER:       sort_cfg.score_trigger       = val[5:0];
			REG_SCORE_RISE:          sort_cfg.score_rise          = val[5:0];
			REG_SCORE_FALL:          sort_cfg.score_fall          = val[5:0];
			REG_SAMPLE_PERIOD:       sort_cfg.sample_period       = val[3:0];
			default: begin
			end
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_cfg(input cfg_t c);
		settle();
		write_reg(REG_ALLIANCE_IS_BLUE, {7'd0, c.alliance_is_blue});
		write_reg(REG_SORT_ENABLE, {7'd0, c.sort_enable});
		write_reg(REG_PROXIMITY_THRESHOLD, c.proximity_threshold);
		write_reg(REG_SCORE_LIMIT, {2'd0, c.score_limit});
		write_reg(REG_SCORE_TRIGGER, {2'd0, c.score_trigger});
		write_reg(REG_SCORE_RISE, {2'd0, c.score_rise});
		write_reg(REG_SCORE_FALL, {2'd0, c.score_fall});
		write_reg(REG_SAMPLE_PERIOD, {4'd0, c.sample_period});
	endtask

	// edges, holds, toggles back to off and several edges in one tick
	task automatic test_mode_buttons();
		send_tick(6'h01, 8'd0, 9'd0);
		send_tick(6'h20, 8'd0, 9'd0);
		send_tick(6'h10, 8'd0, 9'd0);
		send_tick(6'h08, 8'd0, 9'd0);
		send_tick(6'h04, 8'd0, 9'd0);
		send_tick(6'h02, 8'd0, 9'd0);
		send_tick(6'h02, 8'd0, 9'd0);
		send_tick(6'h00, 8'd0, 9'd0);
		send_tick(6'h02, 8'd0, 9'd0);
		send_tick(6'h3F, 8'd0, 9'd0);
		send_tick(6'h00, 8'd0, 9'd0);
		send_tick(6'h1F, 8'd0, 9'd0);
		send_tick(6'h00, 8'd0, 9'd0);
		send_tick(6'h08, 8'd0, 9'd0);
		send_tick(6'h00, 8'd0, 9'd0);
		send_tick(6'h08, 8'd0, 9'd0);
	endtask

	// window edges, proximity at and above threshold, hue out of range
	task automatic test_colour_windows();
		send_tick(6'h01, 8'd255, 9'd215);
		send_tick(6'h00, 8'd255, 9'd250);
		send_tick(6'h00, 8'd41, 9'd230);
		send_tick(6'h00, 8'd40, 9'd230);
		send_tick(6'h00, 8'd255, 9'd360);
		send_tick(6'h00, 8'd255, 9'd361);
		send_tick(6'h00, 8'd255, 9'd511);
		send_tick(6'h00, 8'd0, 9'd0);
	endtask

	// leave the phase past a shorter period, then shorten it
	task automatic test_phase_wrap();
		settle();
		write_reg(REG_SAMPLE_PERIOD, 8'd8);
		repeat (5) send_tick(6'h00, 8'd255, 9'd230);
		settle();
		write_reg(REG_SAMPLE_PERIOD, 8'd2);
		repeat (3) send_tick(6'h00, 8'd255, 9'd230);
	endtask

	task automatic test_backpressure();
		settle();
		tx_gaps = 1'b0;
		hold_cycles = 60;
		repeat (20) send_tick(6'h00, 8'd255, 9'd240);
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_ticks();
		cfg_t       c;
		logic [5:0] btn;
		logic [5:0] last_btn;
		logic [7:0] prox;
		logic [8:0] hue;
		int         r;
		last_btn = intake_st.prev_btn;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: c = '{1'b0, 1'b0, 8'd0, 6'd0, 6'd0, 6'd0, 6'd0, 4'd0};
				1: c = '{1'b1, 1'b1, 8'd255, 6'd63, 6'd63, 6'd63, 6'd63, 4'd15};
				2: c = '{1'b1, RST_SORT_ENABLE, RST_PROXIMITY_THRESHOLD, RST_SCORE_LIMIT,
					RST_SCORE_TRIGGER, RST_SCORE_RISE, RST_SCORE_FALL, RST_SAMPLE_PERIOD};
				default: begin
					c.alliance_is_blue    = 1'($urandom_range(0, 1));
					c.sort_enable         = $urandom_range(0, 3) != 0;
					c.proximity_threshold = 8'($urandom_range(0, 120));
					c.score_limit         = 6'($urandom_range(0, 63));
					c.score_trigger       = 6'($urandom_range(0, 20));
					c.score_rise          = 6'($urandom_range(0, 20));
					c.score_fall          = 6'($urandom_range(0, 20));
					c.sample_period       = 4'($urandom_range(0, 15));
				end
			endcase
			apply_cfg(c);
			tx_gaps = (p % 3) != 2;
			rx_gaps = (p % 3) != 2;
			repeat (50) begin
				r = $urandom_range(0, 19);
				if (r < 12)
					btn = '0;
				else if (r < 17)
					btn = 6'd1 << (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5));
				else if (r < 19)
					btn = 6'($urandom);
				else
					btn = last_btn;
				case ($urandom_range(0, 5))
					0: hue = 9'($urandom_range(300, 360));
					1: hue = 9'($urandom_range(215, 250));
					2: hue = HUE_EDGES[$urandom_range(0, 7)];
					5: hue = 9'($urandom_range(361, 511));
					default: hue = 9'($urandom_range(0, 511));
				endcase
				if ($urandom_range(0, 1))
					prox = 8'($urandom);
				else
					prox = 8'(int'(sort_cfg.proximity_threshold) + $urandom_range(0, 2) - 1);
				send_tick(btn, prox, hue);
				last_btn = btn;
			end
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	initial begin
		intake_st = '0;
		sort_cfg  = '{RST_ALLIANCE_IS_BLUE, RST_SORT_ENABLE, RST_PROXIMITY_THRESHOLD,
			RST_SCORE_LIMIT, RST_SCORE_TRIGGER, RST_SCORE_RISE, RST_SCORE_FALL, RST_SAMPLE_PERIOD};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_mode_buttons();
		test_colour_windows();
		test_phase_wrap();
		test_backpressure();
		test_random_ticks();
		settle();
		repeat (8) @(negedge clk);
		$display("covered %0d ticks and %0d command beats over %0d register writes",
			ticks_sent, cmds_checked, reg_writes);
		$display("input held off for %0d cycles by output back-pressure", input_stalls);
		if (errors == 0 && pending_cmds.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== intake_mode_color_sort_control.f =====
rtl/core/imcsc_pkg.sv
rtl/core/imcsc_step.sv
rtl/core/intake_mode_color_sort_control.sv
rtl/core/imcsc_checker.sv
sim/tb_top.sv
